// File: hw/rtl/ksb_pkg.sv
// ----------------------------------------------------------------------------
// ksb_pkg - shared types and constants for the keyed slot buffer
// Item and result layouts, status and mode codes, register indexes and the
// command bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package ksb_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE        = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ON_ENTERPRISE = 1'b1;
  localparam logic [CFG_DATA_W-1:0] SLOTS_IN_USE_RESET     = 5'd16;

  // Largest slot count the 5-bit register can select
  localparam int unsigned SEARCH_MAX = (1 << CFG_DATA_W) - 1;

  // Item mode codes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_WRITTEN = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_FOUND   = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [15:0] op_id;
    logic [7:0]  client;
    logic [7:0]  enterprise;
    logic [63:0] payload;
    logic [7:0]  wanted_id;
  } ksb_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_op_id;
    logic [7:0]  found_client;
    logic [7:0]  found_enterprise;
    logic [63:0] found_payload;
  } ksb_result_t;

  // One stored record
  typedef struct packed {
    logic [15:0] op_id;
    logic [7:0]  client;
    logic [7:0]  enterprise;
    logic [63:0] payload;
  } ksb_rec_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming item
    logic find;  // search the slots and commit the update
  } ksb_cmd_t;

endpackage

// File: hw/rtl/ksb_dp.sv
// ----------------------------------------------------------------------------
// ksb_dp - keyed slot buffer datapath
// Holds used marks, key copies and the record memory; runs the lowest-match
// search and builds the result.
// ----------------------------------------------------------------------------
module ksb_dp import ksb_pkg::*; #(
  parameter int unsigned SEARCH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ksb_cmd_t              cmd,
  input  ksb_item_t             item,
  input  logic [CFG_DATA_W-1:0] slots_in_use,
  input  logic                  match_on_enterprise,
  output ksb_result_t           result
);

  localparam int unsigned IDX_W = $clog2(SEARCH);

  ksb_item_t        req;
  logic [SEARCH-1:0] used;
  logic [7:0]       key_client [SEARCH];
  logic [7:0]       key_ent    [SEARCH];
  ksb_rec_t         rec_mem    [SEARCH];
  ksb_rec_t         rd_rec;
  ksb_rec_t         wr_rec;
  logic [1:0]       status;
  logic             out_found;

  logic [SEARCH-1:0] cand;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             is_read;

  assign is_read = (req.mode == MODE_READ);
  assign wr_rec  = '{op_id: req.op_id, client: req.client,
                     enterprise: req.enterprise, payload: req.payload};

  // Hold the item for the search cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= item;
    end
  end

  // Candidate slots: free ones for a write, matching used ones for a read
  always_comb begin
    for (int i = 0; i < SEARCH; i++) begin
      if (CFG_DATA_W'(i) >= slots_in_use) begin
        cand[i] = 1'b0;
      end else if (is_read) begin
        cand[i] = used[i] &&
                  ((match_on_enterprise ? key_ent[i] : key_client[i]) == req.wanted_id);
      end else begin
        cand[i] = !used[i];
      end
    end
  end

  // Lowest candidate wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = SEARCH - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.find && hit) begin
      used[hit_idx] <= !is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find && hit && !is_read) begin
      key_client[hit_idx] <= req.client;
      key_ent[hit_idx]    <= req.enterprise;
    end
  end

  // Record memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.find && hit && !is_read) begin
      rec_mem[hit_idx] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find && hit && is_read) begin
      rd_rec <= rec_mem[hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      out_found <= is_read && hit;
      if (is_read) begin
        status <= hit ? ST_FOUND : ST_NONE;
      end else begin
        status <= hit ? ST_WRITTEN : ST_DROPPED;
      end
    end
  end

  always_comb begin
    result.status           = status;
    result.found_op_id      = out_found ? rd_rec.op_id      : '0;
    result.found_client     = out_found ? rd_rec.client     : '0;
    result.found_enterprise = out_found ? rd_rec.enterprise : '0;
    result.found_payload    = out_found ? rd_rec.payload    : '0;
  end

`ifndef SYNTHESIS
  a_read_frees_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.find && hit && is_read) |=> !used[$past(hit_idx)])
    else $error("read hit left its slot marked used");

  a_write_takes_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.find && hit && !is_read) |=> used[$past(hit_idx)])
    else $error("write hit did not mark its slot used");
`endif

endmodule

// File: hw/rtl/ksb_ctrl.sv
// ----------------------------------------------------------------------------
// ksb_ctrl - keyed slot buffer controller
// Sequences capture, search and result strobe for one item at a time.
// ----------------------------------------------------------------------------
module ksb_ctrl import ksb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output ksb_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign busy     = (state == S_FIND);
  assign done     = (state == S_OUT);
  assign accept   = start && !busy;
  assign cmd.load = accept;
  assign cmd.find = (state == S_FIND);

  always_comb begin
    case (state)
      S_IDLE:  state_next = accept ? S_FIND : S_IDLE;
      S_FIND:  state_next = S_OUT;
      S_OUT:   state_next = accept ? S_FIND : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_find: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item did not enter the search cycle");

  a_find_to_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("search cycle not followed by exactly one result strobe");

  a_done_after_find: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding search");
`endif

endmodule

// File: hw/rtl/keyed_slot_buffer.sv
// ----------------------------------------------------------------------------
// keyed_slot_buffer - tagged record store with first-free insert and
// first-match remove
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// For each item, the accept edge captures it, the next cycle
// runs the key compare and priority search over the slots and commits the
// update, and the result is shown on the following cycle with done high for
// exactly that one cycle. A new item may be accepted in the cycle its
// predecessor's result is shown, so back-to-back items overlap each result
// with the next capture; busy is high only in the search cycle. The receiver
// cannot stall: sample result whenever done is high. A write (mode 0) places
// the record in the lowest free slot below slots_in_use, or reports status 1
// when none is free. A read (mode 1) removes the lowest used slot whose
// client (or enterprise, per match_on_enterprise) equals wanted_id and
// returns its record with status 2, or status 3 with zero fields. Writes and
// drops return zero record fields. The slot count register is 5 bits, so
// at most 31 slots can ever be searched; storage is built for the smaller of
// SLOTS and 31. cfg_ready is always high; write configuration only while no
// item is in flight.
// ----------------------------------------------------------------------------
module keyed_slot_buffer import ksb_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  ksb_item_t             item,
  output logic                  done,
  output ksb_result_t           result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Only the slots the count register can reach are built
  localparam int unsigned SEARCH = (SLOTS < SEARCH_MAX) ? SLOTS : SEARCH_MAX;

  logic [CFG_DATA_W-1:0] slots_in_use;
  logic                  match_on_enterprise;
  ksb_cmd_t              cmd;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use        <= SLOTS_IN_USE_RESET;
      match_on_enterprise <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLOTS_IN_USE:        slots_in_use        <= cfg_data;
        CFG_MATCH_ON_ENTERPRISE: match_on_enterprise <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequence capture, search and result strobe
  ksb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Slot storage, search and result formatting
  ksb_dp #(
    .SEARCH (SEARCH)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .item                (item),
    .slots_in_use        (slots_in_use),
    .match_on_enterprise (match_on_enterprise),
    .result              (result)
  );

endmodule

// File: verif/tb_keyed_slot_buffer.sv
// ----------------------------------------------------------------------------
// tb_keyed_slot_buffer - self-checking bench for the keyed slot buffer
// Drives write and read items through the start/busy command port and checks
// every done-strobed result against an in-bench slot store. Covers the field
// extremes, client and enterprise key selection and slot count edges, then
// random traffic under several slot counts and sender idle rates.
// ----------------------------------------------------------------------------
module tb_keyed_slot_buffer;
  import ksb_pkg::*;

  localparam int unsigned SLOTS = 16;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  ksb_item_t             item;
  logic                  done;
  ksb_result_t           result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  keyed_slot_buffer #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Slot store as the bench believes it to be, plus its own register copy
  ksb_rec_t        slot_rec  [SLOTS];
  bit              slot_busy [SLOTS];
  logic [4:0]      slot_count;
  logic            key_on_enterprise;

  // Results still owed by the block, oldest first
  ksb_result_t     awaited_results [$];
  int unsigned     failures;
  int unsigned     idle_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one item to the slot store and return the result it must produce
  function automatic ksb_result_t step_slot_store(ksb_item_t it);
    ksb_result_t r;
    int unsigned n;
    int unsigned i;
    bit          hit;
    logic [7:0]  key;
    r   = '0;
    hit = 1'b0;
    n   = (slot_count > SLOTS) ? SLOTS : slot_count;
    if (it.mode == MODE_WRITE) begin
      r.status = ST_DROPPED;
      for (i = 0; i < n && !hit; i++) begin
        if (!slot_busy[i]) begin
          slot_busy[i]           = 1'b1;
          slot_rec[i].op_id      = it.op_id;
          slot_rec[i].client     = it.client;
          slot_rec[i].enterprise = it.enterprise;
          slot_rec[i].payload    = it.payload;
          r.status               = ST_WRITTEN;
          hit                    = 1'b1;
        end
      end
    end else begin
      r.status = ST_NONE;
      for (i = 0; i < n && !hit; i++) begin
        if (slot_busy[i]) begin
          key = key_on_enterprise ? slot_rec[i].enterprise : slot_rec[i].client;
          if (key == it.wanted_id) begin
            slot_busy[i]       = 1'b0;
            r.status           = ST_FOUND;
            r.found_op_id      = slot_rec[i].op_id;
            r.found_client     = slot_rec[i].client;
            r.found_enterprise = slot_rec[i].enterprise;
            r.found_payload    = slot_rec[i].payload;
            hit                = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic ksb_item_t make_write(logic [15:0] op, logic [7:0] cl,
                                           logic [7:0] ent, logic [63:0] pl);
    ksb_item_t it;
    it.mode       = MODE_WRITE;
    it.op_id      = op;
    it.client     = cl;
    it.enterprise = ent;
    it.payload    = pl;
    it.wanted_id  = 8'($urandom);
    return it;
  endfunction

  // Record fields of a read carry noise; the block must ignore them
  function automatic ksb_item_t make_read(logic [7:0] want);
    ksb_item_t it;
    it.mode       = MODE_READ;
    it.op_id      = 16'($urandom);
    it.client     = 8'($urandom);
    it.enterprise = 8'($urandom);
    it.payload    = {$urandom, $urandom};
    it.wanted_id  = want;
    return it;
  endfunction

  // Send one item: idle first at the current rate, then hold start until the
  // accept edge and predict its result there. Start stays high on return.
  task automatic send_item(ksb_item_t it);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    awaited_results.push_back(step_slot_store(it));
  endtask

  // Drop start and hold until every owed result has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write one register once the block is idle
  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SLOTS_IN_USE)
      slot_count = data;
    else
      key_on_enterprise = data[0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Check each strobed result against the oldest owed one
  always @(posedge clk) begin
    ksb_result_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: status=%0d op_id=%h", result.status,
                   result.found_op_id);
      end else begin
        want = awaited_results.pop_front();
        if (result.status !== want.status ||
            result.found_op_id !== want.found_op_id ||
            result.found_client !== want.found_client ||
            result.found_enterprise !== want.found_enterprise ||
            result.found_payload !== want.found_payload) begin
          failures++;
          if (failures <= 10)
            $display("exp st=%0d id=%h cl=%h en=%h pl=%h, got st=%0d id=%h cl=%h en=%h pl=%h",
                     want.status, want.found_op_id, want.found_client,
                     want.found_enterprise, want.found_payload,
                     result.status, result.found_op_id, result.found_client,
                     result.found_enterprise, result.found_payload);
        end
      end
    end
  end

  // Read on empty, then store records at the field extremes and remove one
  task automatic test_field_extremes();
    send_item(make_read(8'h00));
    send_item(make_write(16'hFFFF, 8'hFF, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF));
    send_item(make_write(16'h0000, 8'h00, 8'hFF, 64'h0));
    send_item(make_read(8'hFF));
    send_item(make_read(8'hFF));
  endtask

  // Switch the key to the enterprise field and remove the remaining record
  task automatic test_key_select();
    set_register(CFG_MATCH_ON_ENTERPRISE, 5'b11111);
    send_item(make_read(8'hFF));
    send_item(make_read(8'h00));
  endtask

  // Zero count drops everything; one slot fills at once; counts above the
  // built size saturate; slots beyond a lowered count keep their records
  task automatic test_slot_count_edges();
    set_register(CFG_SLOTS_IN_USE, 5'd0);
    send_item(make_write(16'h1234, 8'h11, 8'h22, 64'h0123_4567_89AB_CDEF));
    send_item(make_read(8'h00));
    set_register(CFG_SLOTS_IN_USE, 5'd1);
    set_register(CFG_MATCH_ON_ENTERPRISE, 5'b00000);
    send_item(make_write(16'hA5A5, 8'h3C, 8'hC3, 64'hDEAD_BEEF_0000_0001));
    send_item(make_write(16'h5A5A, 8'h3C, 8'h44, 64'h1));
    set_register(CFG_SLOTS_IN_USE, 5'd31);
    send_item(make_write(16'h0101, 8'h77, 8'h88, 64'h8000_0000_0000_0000));
    send_item(make_write(16'h0202, 8'h77, 8'h99, 64'h7FFF_FFFF_FFFF_FFFE));
    set_register(CFG_SLOTS_IN_USE, 5'd1);
    send_item(make_read(8'h77));
    set_register(CFG_SLOTS_IN_USE, 5'd17);
    send_item(make_read(8'h77));
    send_item(make_read(8'h77));
    send_item(make_read(8'h3C));
    send_item(make_read(8'h77));
    set_register(CFG_SLOTS_IN_USE, SLOTS_IN_USE_RESET);
  endtask

  // One chunk of random traffic: a random write/read mix, reads mostly aiming at a stored key,
  // keys drawn from a small pool so duplicates and full stores occur
  task automatic test_random_traffic(int unsigned count_items, logic [4:0] count,
                                     logic on_ent, int unsigned idle);
    logic [7:0]  stored_keys [$];
    logic [7:0]  key;
    int unsigned write_pct;
    int unsigned n;
    int unsigned k;
    int unsigned j;
    set_register(CFG_SLOTS_IN_USE, count);
    set_register(CFG_MATCH_ON_ENTERPRISE, {4'($urandom), on_ent});
    idle_pct  = idle;
    write_pct = $urandom_range(35, 65);
    for (k = 0; k < count_items; k++) begin
      // Pause now and then until the block has answered everything
      if ($urandom_range(0, 49) == 0)
        wait_drained();
      if ($urandom_range(0, 99) < write_pct) begin
        send_item(make_write(16'($urandom),
                             ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3))
                                                        : 8'($urandom),
                             ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3))
                                                        : 8'($urandom),
                             {$urandom, $urandom}));
      end else begin
        stored_keys.delete();
        n = (slot_count > SLOTS) ? SLOTS : slot_count;
        for (j = 0; j < n; j++)
          if (slot_busy[j])
            stored_keys.push_back(key_on_enterprise ? slot_rec[j].enterprise
                                                    : slot_rec[j].client);
        j = $urandom_range(0, 9);
        if (j < 6 && stored_keys.size() != 0)
          key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else if (j < 8)
          key = 8'($urandom_range(0, 3));
        else
          key = 8'($urandom);
        send_item(make_read(key));
      end
    end
  endtask

  initial begin
    logic [4:0]  chunk_count [9];
    int unsigned c;
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SLOTS_IN_USE;
    cfg_data  = '0;
    failures  = 0;
    idle_pct  = 0;
    for (c = 0; c < SLOTS; c++) begin
      slot_busy[c] = 1'b0;
      slot_rec[c]  = '0;
    end
    slot_count        = SLOTS_IN_USE_RESET;
    key_on_enterprise = 1'b0;
    chunk_count = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd2, 5'd16};
    chunk_count[6] = 5'($urandom_range(2, 15));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_field_extremes();
    test_key_select();
    test_slot_count_edges();
    // Sender idles at 18 percent, then 54 percent, then not at all
    for (c = 0; c < 9; c++)
      test_random_traffic(100, chunk_count[c], c[0], (c < 3) ? 18 : (c < 6) ? 54 : 0);

    start <= 1'b0;
    for (c = 0; c < 1000 && awaited_results.size() != 0; c++) @(posedge clk);
    repeat (8) @(posedge clk);
    failures += awaited_results.size();
    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ksb_pkg.sv
hw/rtl/ksb_dp.sv
hw/rtl/ksb_ctrl.sv
hw/rtl/keyed_slot_buffer.sv
verif/tb_keyed_slot_buffer.sv
